// ----- sv/cbpe_pkg.sv -----
// cbpe_pkg: shared types, constants and register codes of the cubic bezier point evaluator
// used by cbpe_weight, cbpe_blend and cubic_bezier_point_eval; depends on nothing
package cbpe_pkg;

    // default sizes
    localparam int COORD_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 10;

    // curve parameter t and 1-t in Q0.16, one extra bit to hold 1.0
    localparam int T_BITS    = 17;
    localparam int STEP_BITS = 17;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << (T_BITS - 1);

    // squares are Q0.32, bernstein weights are Q0.48 and reach 2^48
    localparam int SQ_BITS = 2 * T_BITS;
    localparam int W_BITS  = 3 * (T_BITS - 1) + 1;
    localparam int W_SPLIT = 24;

    localparam int NUM_PTS   = 4;
    localparam int NUM_COORD = 3;

    // pipeline depth of the evaluator, input to output
    localparam int PIPE_DEPTH = 7;

    // configuration register codes
    localparam int CFG_ADDR_BITS = 3;
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_POINT_ZERO  = 3'd0,
        REG_POINT_ONE   = 3'd1,
        REG_POINT_TWO   = 3'd2,
        REG_POINT_THREE = 3'd3,
        REG_STEP_SIZE   = 3'd4
    } t_cfg_reg;

    // reset values of the configuration registers
    localparam logic [47:0] POINT_ZERO_RST  = 48'd277081158057984;
    localparam logic [47:0] POINT_ONE_RST   = 48'd279276020563968;
    localparam logic [47:0] POINT_TWO_RST   = 48'd2203251113984;
    localparam logic [47:0] POINT_THREE_RST = 48'd4398113619968;
    localparam logic [STEP_BITS-1:0] STEP_SIZE_RST = 17'd662;

    // four bernstein weights, index k weights control point k
    typedef logic [NUM_PTS-1:0][W_BITS-1:0] t_weight_set;

    // stage advance strobes of the weight pipeline
    typedef struct packed {
        logic ramp;
        logic square;
        logic cube;
        logic weight;
    } t_weight_adv;

    // stage advance strobes of one blend lane
    typedef struct packed {
        logic prod;
        logic sum;
        logic rnd;
    } t_blend_adv;

    // three times a weight term, kept to weight width (the result never exceeds 2^48)
    function automatic logic [W_BITS-1:0] times_three(input logic [W_BITS-1:0] x);
        logic [W_BITS:0] s;
        s = {x, 1'b0} + {1'b0, x};
        return s[W_BITS-1:0];
    endfunction

endpackage

// ----- sv/cubic_bezier_point_eval.sv -----
// Cubic bezier point evaluator. Each accepted sample index i gives t = i * step_size (Q0.16,
// clamped at 1.0) and one result: the x, y and z of the curve through the four configured
// control points, rounded to nearest (ties up) in the coordinate format. The block takes one
// transaction per clock while the output is not stalled, and throughput is then one point per
// clock, set by the fully pipelined multipliers (the deepest stage is one 34x17 product). Stall
// from the output backs up through the pipeline, and the input is stalled only once every
// stage holds a point. Configuration is written through a plain write port; the user must
// write it only while no transaction is in flight, as the block does not enforce this.
// Depends on cbpe_pkg, cbpe_weight and cbpe_blend.
module cubic_bezier_point_eval #(
    parameter int  COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int  INDEX_BITS = cbpe_pkg::INDEX_BITS_DEF,
    localparam int PT_BITS    = (3 * COORD_BITS >= 64) ? 64 : 3 * COORD_BITS,
    localparam int CFG_BITS   = (PT_BITS > cbpe_pkg::STEP_BITS) ? PT_BITS : cbpe_pkg::STEP_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [cbpe_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [CFG_BITS-1:0]                   i_cfg_wdata,
    // sample index channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [INDEX_BITS-1:0]                 i_sample_index,
    // curve point channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [COORD_BITS-1:0]          o_pos_x,
    output logic signed [COORD_BITS-1:0]          o_pos_y,
    output logic signed [COORD_BITS-1:0]          o_pos_z
);
    import cbpe_pkg::*;

    localparam int EXT_BITS = 3 * COORD_BITS;
    localparam logic [COORD_BITS-1:0] SIGN_BIT = COORD_BITS'(1) << (COORD_BITS - 1);

    logic [NUM_PTS-1:0][PT_BITS-1:0] r_point;
    logic [STEP_BITS-1:0]            r_step_size;
    logic [PIPE_DEPTH:1]             r_vld;
    logic [PIPE_DEPTH:1]             adv;

    t_weight_adv  weight_adv;
    t_blend_adv   blend_adv;
    t_weight_set  weight;
    logic [W_BITS+1:0] weight_sum;
    logic [EXT_BITS-1:0] point_ext [NUM_PTS];
    logic [NUM_COORD-1:0][NUM_PTS-1:0][COORD_BITS-1:0] coord;
    logic signed [COORD_BITS-1:0] pos [NUM_COORD];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point[0]  <= PT_BITS'(POINT_ZERO_RST);
            r_point[1]  <= PT_BITS'(POINT_ONE_RST);
            r_point[2]  <= PT_BITS'(POINT_TWO_RST);
            r_point[3]  <= PT_BITS'(POINT_THREE_RST);
            r_step_size <= STEP_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_POINT_ZERO:  r_point[0]  <= i_cfg_wdata[PT_BITS-1:0];
                REG_POINT_ONE:   r_point[1]  <= i_cfg_wdata[PT_BITS-1:0];
                REG_POINT_TWO:   r_point[2]  <= i_cfg_wdata[PT_BITS-1:0];
                REG_POINT_THREE: r_point[3]  <= i_cfg_wdata[PT_BITS-1:0];
                REG_STEP_SIZE:   r_step_size <= i_cfg_wdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // unpack control coordinates to offset binary, x on top; bits past the register read as zero
    always_comb begin
        for (int k = 0; k < NUM_PTS; k++) begin
            point_ext[k] = EXT_BITS'(r_point[k]);
            for (int c = 0; c < NUM_COORD; c++) begin
                coord[c][k] = point_ext[k][(NUM_COORD - 1 - c) * COORD_BITS +: COORD_BITS]
                              ^ SIGN_BIT;
            end
        end
    end

    // stage advance: a stage moves when empty or when the one after it moves
    always_comb begin
        adv[PIPE_DEPTH] = !r_vld[PIPE_DEPTH] || !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        weight_adv.ramp   = adv[1];
        weight_adv.square = adv[2];
        weight_adv.cube   = adv[3];
        weight_adv.weight = adv[4];
        blend_adv.prod    = adv[5];
        blend_adv.sum     = adv[6];
        blend_adv.rnd     = adv[7];
    end

    // bernstein weights
    cbpe_weight #(
        .INDEX_BITS (INDEX_BITS)
    ) u_weight (
        .i_clk          (i_clk),
        .i_adv          (weight_adv),
        .i_sample_index (i_sample_index),
        .i_step_size    (r_step_size),
        .o_weight       (weight)
    );

    // one blend lane per coordinate
    for (genvar c = 0; c < NUM_COORD; c++) begin : g_lane
        cbpe_blend #(
            .COORD_BITS (COORD_BITS)
        ) u_blend (
            .i_clk    (i_clk),
            .i_adv    (blend_adv),
            .i_weight (weight),
            .i_coord  (coord[c]),
            .o_pos    (pos[c])
        );
    end

    assign o_stall = !adv[1];
    assign o_valid = r_vld[PIPE_DEPTH];
    assign o_pos_x = pos[0];
    assign o_pos_y = pos[1];
    assign o_pos_z = pos[2];

    // weights of a live point form a partition of one
    always_comb begin
        weight_sum = '0;
        for (int k = 0; k < NUM_PTS; k++) begin
            weight_sum = weight_sum + (W_BITS + 2)'(weight[k]);
        end
    end

    a_weight_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> weight_sum == ((W_BITS + 2)'(1) << (W_BITS - 1)))
        else $error("bernstein weights do not sum to one");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output takes a transaction");

endmodule

// ----- sv/cbpe_weight.sv -----
// cbpe_weight: four-stage pipeline from sample index to the four bernstein weights
// depends on cbpe_pkg
module cbpe_weight #(
    parameter int INDEX_BITS = cbpe_pkg::INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  cbpe_pkg::t_weight_adv               i_adv,
    input  logic [INDEX_BITS-1:0]               i_sample_index,
    input  logic [cbpe_pkg::STEP_BITS-1:0]      i_step_size,
    output cbpe_pkg::t_weight_set               o_weight
);
    import cbpe_pkg::*;

    localparam int RAMP_BITS = INDEX_BITS + STEP_BITS;

    logic [RAMP_BITS-1:0] ramp;
    logic [T_BITS-1:0]    n_t;

    logic [T_BITS-1:0]  r_t1, r_u1;
    logic [T_BITS-1:0]  r_t2, r_u2;
    logic [SQ_BITS-1:0] r_tt2, r_uu2;
    logic [W_BITS-1:0]  r_u3, r_tu2, r_t2u, r_t3;
    t_weight_set        r_w;

    // t = index * step, clamped at one
    always_comb begin
        ramp = RAMP_BITS'(i_sample_index) * RAMP_BITS'(i_step_size);
        n_t  = (ramp > RAMP_BITS'(T_ONE)) ? T_ONE : ramp[T_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        // stage 1: t and 1-t
        if (i_adv.ramp) begin
            r_t1 <= n_t;
            r_u1 <= T_ONE - n_t;
        end
        // stage 2: squares
        if (i_adv.square) begin
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_tt2 <= SQ_BITS'(r_t1) * SQ_BITS'(r_t1);
            r_uu2 <= SQ_BITS'(r_u1) * SQ_BITS'(r_u1);
        end
        // stage 3: cubic products
        if (i_adv.cube) begin
            r_u3  <= W_BITS'(r_uu2) * W_BITS'(r_u2);
            r_tu2 <= W_BITS'(r_uu2) * W_BITS'(r_t2);
            r_t2u <= W_BITS'(r_tt2) * W_BITS'(r_u2);
            r_t3  <= W_BITS'(r_tt2) * W_BITS'(r_t2);
        end
        // stage 4: binomial factors
        if (i_adv.weight) begin
            r_w[0] <= r_u3;
            r_w[1] <= times_three(r_tu2);
            r_w[2] <= times_three(r_t2u);
            r_w[3] <= r_t3;
        end
    end

    assign o_weight = r_w;

endmodule

// ----- sv/cbpe_blend.sv -----
// cbpe_blend: one coordinate lane, weighted sum of four control coordinates and rounding
// three stages: split products, sums, round to the coordinate format; depends on cbpe_pkg
module cbpe_blend #(
    parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  cbpe_pkg::t_blend_adv                 i_adv,
    input  cbpe_pkg::t_weight_set                i_weight,
    // control coordinates in offset binary
    input  logic [cbpe_pkg::NUM_PTS-1:0][COORD_BITS-1:0] i_coord,
    output logic signed [COORD_BITS-1:0]         o_pos
);
    import cbpe_pkg::*;

    localparam int HI_BITS = W_BITS - W_SPLIT;
    localparam int HP_BITS = HI_BITS + COORD_BITS;
    localparam int LP_BITS = W_SPLIT + COORD_BITS;
    localparam int HS_BITS = HP_BITS + 2;
    localparam int LS_RAW  = (LP_BITS + 2 > 2 * W_SPLIT - 1) ? LP_BITS + 2 : 2 * W_SPLIT - 1;
    localparam int LS_BITS = LS_RAW + 1;
    localparam int Q_RAW   = (HS_BITS > LS_BITS - W_SPLIT) ? HS_BITS : LS_BITS - W_SPLIT;
    localparam int Q_BITS  = Q_RAW + 1;
    localparam logic [LS_BITS-1:0]    HALF_LSB = LS_BITS'(1) << (2 * W_SPLIT - 1);
    localparam logic [COORD_BITS-1:0] SIGN_BIT = COORD_BITS'(1) << (COORD_BITS - 1);

    logic [NUM_PTS-1:0][HP_BITS-1:0] r_hi_prod;
    logic [NUM_PTS-1:0][LP_BITS-1:0] r_lo_prod;
    logic [HS_BITS-1:0]    n_hi_sum, r_hi_sum;
    logic [LS_BITS-1:0]    n_lo_sum, r_lo_sum;
    logic [Q_BITS-1:0]     quot;
    logic [COORD_BITS-1:0] n_pos;
    logic [COORD_BITS-1:0] r_pos;

    // stage 5: weight halves times coordinate
    always_ff @(posedge i_clk) begin
        if (i_adv.prod) begin
            for (int k = 0; k < NUM_PTS; k++) begin
                r_hi_prod[k] <= HP_BITS'(i_weight[k][W_BITS-1:W_SPLIT]) * HP_BITS'(i_coord[k]);
                r_lo_prod[k] <= LP_BITS'(i_weight[k][W_SPLIT-1:0]) * LP_BITS'(i_coord[k]);
            end
        end
    end

    // stage 6: sum the halves, half an lsb of the result goes into the low sum
    always_comb begin
        n_hi_sum = '0;
        n_lo_sum = HALF_LSB;
        for (int k = 0; k < NUM_PTS; k++) begin
            n_hi_sum = n_hi_sum + HS_BITS'(r_hi_prod[k]);
            n_lo_sum = n_lo_sum + LS_BITS'(r_lo_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.sum) begin
            r_hi_sum <= n_hi_sum;
            r_lo_sum <= n_lo_sum;
        end
    end

    // stage 7: merge halves, drop the q0.48 fraction, back from offset binary
    always_comb begin
        quot  = Q_BITS'(r_hi_sum) + Q_BITS'(r_lo_sum >> W_SPLIT);
        n_pos = quot[W_SPLIT +: COORD_BITS] ^ SIGN_BIT;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.rnd) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = signed'(r_pos);

endmodule
